### design/rbf_pkg.sv
// Package with payload types, sequencer states and the exponential table functions.
`timescale 1ns / 1ps
package rbf_pkg;

    // Reset values and limits of the configuration registers.
    localparam int DEF_MAX_POINTS = 1024;
    localparam int DEF_EXP_TABLE_ENTRIES = 256;
    localparam logic [10:0] POINT_COUNT_RESET = 11'd1;
    localparam logic [31:0] INV_SIGMA_SQ_RESET = 32'd1099511;
    localparam logic [31:0] BIAS_RESET = 32'd0;

    // Configuration register indexes.
    localparam logic [1:0] REG_POINT_COUNT = 2'd0;
    localparam logic [1:0] REG_INV_SIGMA_SQ = 2'd1;
    localparam logic [1:0] REG_BIAS = 2'd2;

    // Request operation codes.
    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    typedef struct packed {
        logic               operation;
        logic [9:0]         point_index;
        logic signed [23:0] coord_x;
        logic signed [23:0] coord_y;
        logic signed [31:0] weight;
    } t_in;

    typedef struct packed {
        logic signed [47:0] prediction;
        logic               saturated;
    } t_out;

    typedef enum logic [3:0] {
        S_IDLE, S_RD, S_DX, S_MX, S_MY, S_MH, S_ML, S_IX, S_T0, S_T1, S_MF, S_MW, S_FIN
    } t_state;

    // Unsigned long division by shift and subtract, used only on elaboration constants.
    function automatic logic [63:0] div_const(input logic [63:0] num, input logic [63:0] den);
        logic [63:0] quo;
        logic [64:0] rem;
        quo = '0;
        rem = '0;
        for (int b = 63; b >= 0; b--) begin
            rem = {rem[63:0], num[b]};
            if (rem >= 65'(den)) begin
                rem = rem - 65'(den);
                quo[b] = 1'b1;
            end
        end
        return quo;
    endfunction

    // Ratio between neighboring table points in Q2.30, from a truncated Taylor series.
    function automatic logic [63:0] taylor_ratio(input logic [63:0] y30);
        logic [63:0] sum;
        logic [63:0] term;
        sum = 64'd1 << 30;
        term = 64'd1 << 30;
        for (int n = 1; n <= 20; n++) begin
            term = div_const((term * y30) >> 30, 64'(n));
            if (n % 2 == 1) begin
                sum = sum - term;
            end else begin
                sum = sum + term;
            end
        end
        return sum;
    endfunction

    // Table point k in Q1.15, built by repeated rounded products with the ratio.
    function automatic logic [15:0] exp_entry(input int k, input logic [63:0] ratio);
        logic [63:0] q;
        q = 64'd1 << 30;
        for (int j = 1; j <= k; j++) begin
            q = (q * ratio + (64'd1 << 29)) >> 30;
        end
        return 16'((q + (64'd1 << 14)) >> 15);
    endfunction

endpackage

### design/rbf_kernel_regression_eval_top.sv
// RBF kernel regression evaluator: point store, shared multiplier and sequencer.
// A load request with an index below MAX_POINTS writes one store slot.
// A query walks N = min(point_count, MAX_POINTS) stored points: the single shared
// multiplier serves seven products per stored point, and the store is read once per point.
// The result waits in an output register, so a new request can start meanwhile; the final
// step holds while the previous result is still stalled there.
// Synchronous active-low reset clears control state and the configuration registers.
`timescale 1ns / 1ps
module rbf_kernel_regression_eval_top #(
    parameter int MAX_POINTS = rbf_pkg::DEF_MAX_POINTS,
    parameter int EXP_TABLE_ENTRIES = rbf_pkg::DEF_EXP_TABLE_ENTRIES
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_stall,
    input  rbf_pkg::t_in   i_in,
    output logic           o_out_valid,
    input  logic           i_out_stall,
    output rbf_pkg::t_out  o_out,
    input  logic           i_cfg_we,
    input  logic [1:0]     i_cfg_index,
    input  logic [31:0]    i_cfg_data
);

    localparam int AW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
    localparam int CW = $clog2(MAX_POINTS + 1);
    localparam int TW = $clog2(EXP_TABLE_ENTRIES + 1);
    localparam int ACC_MIN = 48 + $clog2(MAX_POINTS) + 1;
    localparam int ACC_W = (ACC_MIN > 63) ? ACC_MIN : 63;
    localparam int QW = ACC_W - 15;
    localparam logic [63:0] Y30 =
        ((64'd16 << 30) + 64'(EXP_TABLE_ENTRIES / 2)) / 64'(EXP_TABLE_ENTRIES);
    localparam logic [63:0] R_RATIO = rbf_pkg::taylor_ratio(Y30);

    // Constant exponential table.
    logic [15:0] w_tab [0:EXP_TABLE_ENTRIES];
    for (genvar g = 0; g <= EXP_TABLE_ENTRIES; g++) begin : g_tab
        assign w_tab[g] = rbf_pkg::exp_entry(g, R_RATIO);
    end

    rbf_pkg::t_state r_state, n_state;

    logic [10:0]        r_point_count;
    logic [31:0]        r_inv_sigma_sq;
    logic signed [31:0] r_bias;

    logic [79:0]        r_mem [0:MAX_POINTS-1];
    logic signed [23:0] r_mx, r_my;
    logic signed [31:0] r_mw;

    logic signed [23:0] r_qx, n_qx, r_qy, n_qy;
    logic signed [31:0] r_w, n_w;
    logic [CW-1:0]      r_pidx, n_pidx, r_cnt, n_cnt;
    logic [23:0]        r_dx, n_dx, r_dy, n_dy;
    logic [48:0]        r_s, n_s;
    logic [21:0]        r_phl, n_phl;
    logic               r_phbig, n_phbig, r_kz, n_kz;
    logic [11:0]        r_a, n_a, r_f, n_f;
    logic [TW-1:0]      r_tidx, n_tidx;
    logic [15:0]        r_t0, n_t0, r_diff, n_diff, r_k, n_k;
    logic signed [ACC_W-1:0] r_acc, n_acc;
    logic               r_out_valid, n_out_valid;
    rbf_pkg::t_out      r_out, n_out;

    logic signed [32:0] w_ma, w_mb;
    logic signed [65:0] w_mp;
    logic               w_in_take, w_out_free;
    logic signed [24:0] w_dxs, w_dys;
    logic [54:0]        w_asum;
    logic [10:0]        w_cnt_lim;
    logic signed [ACC_W-1:0] w_rnd;
    logic signed [QW-1:0]    w_q;

    assign w_in_take = i_in_valid && (r_state == rbf_pkg::S_IDLE);
    assign w_out_free = !r_out_valid || !i_out_stall;
    assign w_mp = w_ma * w_mb;
    assign w_dxs = 25'(r_qx) - 25'(r_mx);
    assign w_dys = 25'(r_qy) - 25'(r_my);
    assign w_asum = 55'({r_phl, 22'd0}) + 55'(w_mp[53:0]);
    assign w_cnt_lim = (32'(r_point_count) > MAX_POINTS) ? 11'(MAX_POINTS) : r_point_count;
    assign w_rnd = r_acc + ACC_W'(16384);
    assign w_q = QW'(w_rnd >>> 15);

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_point_count <= rbf_pkg::POINT_COUNT_RESET;
            r_inv_sigma_sq <= rbf_pkg::INV_SIGMA_SQ_RESET;
            r_bias <= rbf_pkg::BIAS_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                rbf_pkg::REG_POINT_COUNT:  r_point_count <= i_cfg_data[10:0];
                rbf_pkg::REG_INV_SIGMA_SQ: r_inv_sigma_sq <= i_cfg_data;
                rbf_pkg::REG_BIAS:         r_bias <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Point store: written by loads, read once per point with registered data.
    always_ff @(posedge i_clk) begin
        if (w_in_take && i_in.operation == rbf_pkg::OP_LOAD &&
            32'(i_in.point_index) < MAX_POINTS) begin
            r_mem[AW'(i_in.point_index)] <= {i_in.coord_x, i_in.coord_y, i_in.weight};
        end
        if (r_state == rbf_pkg::S_RD) begin
            {r_mx, r_my, r_mw} <= r_mem[r_pidx[AW-1:0]];
        end
    end

    // Next state of the sequencer.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            rbf_pkg::S_IDLE: begin
                if (w_in_take && i_in.operation == rbf_pkg::OP_QUERY) begin
                    n_state = (w_cnt_lim == 11'd0) ? rbf_pkg::S_FIN : rbf_pkg::S_RD;
                end
            end
            rbf_pkg::S_RD: n_state = rbf_pkg::S_DX;
            rbf_pkg::S_DX: n_state = rbf_pkg::S_MX;
            rbf_pkg::S_MX: n_state = rbf_pkg::S_MY;
            rbf_pkg::S_MY: n_state = rbf_pkg::S_MH;
            rbf_pkg::S_MH: n_state = rbf_pkg::S_ML;
            rbf_pkg::S_ML: n_state = rbf_pkg::S_IX;
            rbf_pkg::S_IX: n_state = rbf_pkg::S_T0;
            rbf_pkg::S_T0: n_state = rbf_pkg::S_T1;
            rbf_pkg::S_T1: n_state = rbf_pkg::S_MF;
            rbf_pkg::S_MF: n_state = rbf_pkg::S_MW;
            rbf_pkg::S_MW: begin
                n_state = (CW'(r_pidx + 1'b1) == r_cnt) ? rbf_pkg::S_FIN : rbf_pkg::S_RD;
            end
            rbf_pkg::S_FIN: begin
                if (w_out_free) begin
                    n_state = rbf_pkg::S_IDLE;
                end
            end
            default: n_state = rbf_pkg::S_IDLE;
        endcase
    end

    // Datapath and shared multiplier operand selection.
    always_comb begin
        n_qx = r_qx;
        n_qy = r_qy;
        n_w = r_w;
        n_pidx = r_pidx;
        n_cnt = r_cnt;
        n_dx = r_dx;
        n_dy = r_dy;
        n_s = r_s;
        n_phl = r_phl;
        n_phbig = r_phbig;
        n_kz = r_kz;
        n_a = r_a;
        n_f = r_f;
        n_tidx = r_tidx;
        n_t0 = r_t0;
        n_diff = r_diff;
        n_k = r_k;
        n_acc = r_acc;
        n_out = r_out;
        n_out_valid = r_out_valid && i_out_stall;
        w_ma = '0;
        w_mb = '0;
        unique case (r_state)
            rbf_pkg::S_IDLE: begin
                n_qx = i_in.coord_x;
                n_qy = i_in.coord_y;
                n_pidx = '0;
                n_cnt = CW'(w_cnt_lim);
                n_acc = ACC_W'($signed({r_bias, 15'd0}));
            end
            rbf_pkg::S_RD: ;
            rbf_pkg::S_DX: begin
                n_dx = w_dxs[24] ? 24'(-w_dxs) : 24'(w_dxs);
                n_dy = w_dys[24] ? 24'(-w_dys) : 24'(w_dys);
                n_w = r_mw;
            end
            rbf_pkg::S_MX: begin
                w_ma = 33'(r_dx);
                w_mb = 33'(r_dx);
                n_s = 49'(w_mp[47:0]);
            end
            rbf_pkg::S_MY: begin
                w_ma = 33'(r_dy);
                w_mb = 33'(r_dy);
                n_s = r_s + 49'(w_mp[47:0]);
            end
            rbf_pkg::S_MH: begin
                w_ma = 33'(r_s[48:22]);
                w_mb = 33'(r_inv_sigma_sq);
                n_phl = w_mp[21:0];
                n_phbig = |w_mp[58:22];
            end
            rbf_pkg::S_ML: begin
                w_ma = 33'(r_s[21:0]);
                w_mb = 33'(r_inv_sigma_sq);
                n_a = w_asum[43:32];
                n_kz = r_phbig || (|w_asum[54:44]);
            end
            rbf_pkg::S_IX: begin
                w_ma = 33'(r_a);
                w_mb = 33'(EXP_TABLE_ENTRIES);
                n_tidx = TW'(w_mp[32:12]);
                n_f = w_mp[11:0];
            end
            rbf_pkg::S_T0: begin
                n_t0 = w_tab[r_tidx];
                n_tidx = TW'(r_tidx + 1'b1);
            end
            rbf_pkg::S_T1: begin
                n_diff = r_t0 - w_tab[r_tidx];
            end
            rbf_pkg::S_MF: begin
                w_ma = 33'(r_diff);
                w_mb = 33'(r_f);
                n_k = r_kz ? 16'd0 : 16'(r_t0 - 16'((w_mp[27:0] + 28'd2048) >> 12));
            end
            rbf_pkg::S_MW: begin
                w_ma = 33'(r_w);
                w_mb = 33'(r_k);
                n_acc = r_acc + ACC_W'($signed(w_mp[47:0]));
                n_pidx = CW'(r_pidx + 1'b1);
            end
            rbf_pkg::S_FIN: begin
                if (w_out_free) begin
                    n_out_valid = 1'b1;
                    if ((w_q[QW-1:47] != '0) && (w_q[QW-1:47] != '1)) begin
                        n_out.saturated = 1'b1;
                        n_out.prediction = w_q[QW-1] ? {1'b1, 47'd0} : {1'b0, {47{1'b1}}};
                    end else begin
                        n_out.saturated = 1'b0;
                        n_out.prediction = w_q[47:0];
                    end
                end
            end
            default: ;
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= rbf_pkg::S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    // Datapath registers.
    always_ff @(posedge i_clk) begin
        r_qx <= n_qx;
        r_qy <= n_qy;
        r_w <= n_w;
        r_pidx <= n_pidx;
        r_cnt <= n_cnt;
        r_dx <= n_dx;
        r_dy <= n_dy;
        r_s <= n_s;
        r_phl <= n_phl;
        r_phbig <= n_phbig;
        r_kz <= n_kz;
        r_a <= n_a;
        r_f <= n_f;
        r_tidx <= n_tidx;
        r_t0 <= n_t0;
        r_diff <= n_diff;
        r_k <= n_k;
        r_acc <= n_acc;
        r_out <= n_out;
    end

    assign o_in_stall = (r_state != rbf_pkg::S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out = r_out;

`ifndef SYNTH
    // The point counter never runs past the query's point count.
    a_pidx_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != rbf_pkg::S_IDLE && r_state != rbf_pkg::S_FIN) |-> (r_pidx < r_cnt))
        else $error("point index past point count");

    // An interpolated kernel value never exceeds one in Q1.15.
    a_kernel_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == rbf_pkg::S_MW) |-> (r_k <= 16'd32768))
        else $error("kernel value out of range");

    // A clipped result sits at one of the two range limits.
    a_sat_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out.saturated) |->
        (o_out.prediction == {1'b1, 47'd0} || o_out.prediction == {1'b0, {47{1'b1}}}))
        else $error("saturated result not at a limit");
`endif

endmodule

### tb/tb_rbf_kernel_regression_eval_top.sv
// Self-checking testbench for the RBF kernel regression evaluator.
`timescale 1ns / 1ps
module tb_rbf_kernel_regression_eval_top;

    localparam int NPTS = 1024;
    localparam int LUT_N = 256;
    localparam logic [1:0] REG_UNUSED = 2'd3;
    localparam longint CYCLE_LIMIT = 3000000;
    localparam longint PRED_HI = (longint'(1) <<< 47) - 1;
    localparam longint PRED_LO = -(longint'(1) <<< 47);

    typedef struct {
        logic          is_cfg;
        logic [1:0]    cfg_idx;
        logic [31:0]   cfg_val;
        rbf_pkg::t_in  req;
        logic          has_exp;
        rbf_pkg::t_out exp;
    } t_row;

    typedef struct {
        logic          has_exp;
        rbf_pkg::t_out exp;
    } t_typed;

    logic          i_clk;
    logic          i_rst_n;
    logic          i_in_valid;
    logic          o_in_stall;
    rbf_pkg::t_in  i_in;
    logic          o_out_valid;
    logic          i_out_stall;
    rbf_pkg::t_out o_out;
    logic          i_cfg_we;
    logic [1:0]    i_cfg_index;
    logic [31:0]   i_cfg_data;

    rbf_kernel_regression_eval_top dut (.*);

    // Predictor state: configuration, point store and the exponential table.
    logic [10:0]        pc_reg;
    logic [31:0]        inv_reg;
    logic signed [31:0] bias_reg;
    logic signed [23:0] xs [NPTS];
    logic signed [23:0] ys [NPTS];
    logic signed [31:0] ws [NPTS];
    longint unsigned    exp_lut [LUT_N + 1];

    rbf_pkg::t_out pending_predictions [$];
    t_typed        typed_results [$];
    t_row          directed [$];
    int     idle_pct;
    int     stall_pct;
    bit     failed;
    longint cycles;

    // Clock.
    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // Exponential table in Q1.15, from a Q2.30 ratio built by a truncated series.
    function automatic void build_exp_lut();
        longint unsigned y30, ratio, term, q;
        y30 = ((longint'(16) << 30) + LUT_N / 2) / LUT_N;
        ratio = longint'(1) << 30;
        term = ratio;
        for (int n = 1; n <= 20; n++) begin
            term = ((term * y30) >> 30) / n;
            if (n % 2 == 1) begin
                ratio = ratio - term;
            end else begin
                ratio = ratio + term;
            end
        end
        q = longint'(1) << 30;
        exp_lut[0] = 32768;
        for (int k = 1; k <= LUT_N; k++) begin
            q = (q * ratio + (longint'(1) << 29)) >> 30;
            exp_lut[k] = (q + (longint'(1) << 14)) >> 15;
        end
    endfunction

    // Q1.15 Gaussian weight for a squared distance.
    function automatic longint gauss_weight(longint unsigned dsq);
        longint unsigned hi, lo, ph, arg, p, t0, t1, f;
        int idx;
        hi = dsq >> 22;
        lo = dsq & ((longint'(1) << 22) - 1);
        ph = hi * inv_reg;
        if (ph >= (longint'(1) << 22)) begin
            return 0;
        end
        arg = ((ph << 22) + lo * inv_reg) >> 32;
        if (arg >= 4096) begin
            return 0;
        end
        p = arg * LUT_N;
        idx = int'(p >> 12);
        f = p & 4095;
        t0 = exp_lut[idx];
        t1 = exp_lut[idx + 1];
        return longint'(t0 - (((t0 - t1) * f + 2048) >> 12));
    endfunction

    // Saturated prediction at a query point.
    function automatic rbf_pkg::t_out predict_value(logic signed [23:0] qx,
                                                    logic signed [23:0] qy);
        longint acc, dx, dy, q;
        int cnt;
        rbf_pkg::t_out r;
        cnt = (pc_reg > NPTS) ? NPTS : int'(pc_reg);
        acc = longint'(bias_reg) * 32768;
        for (int i = 0; i < cnt; i++) begin
            dx = longint'(qx) - longint'(xs[i]);
            dy = longint'(qy) - longint'(ys[i]);
            acc += longint'(ws[i]) * gauss_weight(longint'(dx * dx + dy * dy));
        end
        q = (acc + 16384) >>> 15;
        r.saturated = 1'b0;
        if (q > PRED_HI) begin
            q = PRED_HI;
            r.saturated = 1'b1;
        end else if (q < PRED_LO) begin
            q = PRED_LO;
            r.saturated = 1'b1;
        end
        r.prediction = q[47:0];
        return r;
    endfunction

    // Accepted requests update the store or queue the expected prediction.
    always @(posedge i_clk) begin
        t_typed t;
        if (i_rst_n && i_in_valid && !o_in_stall) begin
            if (i_in.operation == rbf_pkg::OP_LOAD) begin
                xs[i_in.point_index] = i_in.coord_x;
                ys[i_in.point_index] = i_in.coord_y;
                ws[i_in.point_index] = i_in.weight;
            end else begin
                t = typed_results.pop_front();
                if (t.has_exp) begin
                    pending_predictions.push_back(t.exp);
                end else begin
                    pending_predictions.push_back(predict_value(i_in.coord_x, i_in.coord_y));
                end
            end
        end
    end

    // Accepted results are compared with the oldest expectation.
    always @(posedge i_clk) begin
        rbf_pkg::t_out e;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_predictions.size() == 0) begin
                $error("unexpected result: prediction %0d", o_out.prediction);
                failed = 1'b1;
            end else begin
                e = pending_predictions.pop_front();
                if (o_out.prediction !== e.prediction) begin
                    $error("prediction: expected %0d got %0d", e.prediction, o_out.prediction);
                    failed = 1'b1;
                end
                if (o_out.saturated !== e.saturated) begin
                    $error("saturated: expected %0d got %0d", e.saturated, o_out.saturated);
                    failed = 1'b1;
                end
            end
        end
    end

    // Result-side stalls.
    always @(negedge i_clk) begin
        i_out_stall <= ($urandom_range(99) < stall_pct);
    end

    // Watchdog.
    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("tb_rbf_kernel_regression_eval_top failed");
            $finish;
        end
    end

    // Drive one request, with random idle cycles ahead of it; returns at a falling edge.
    task automatic send_request(rbf_pkg::t_in r, logic has_exp = 1'b0,
                                rbf_pkg::t_out exp = '0);
        t_typed t;
        while ($urandom_range(99) < idle_pct) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        if (r.operation == rbf_pkg::OP_QUERY) begin
            t.has_exp = has_exp;
            t.exp = exp;
            typed_results.push_back(t);
        end
        i_in_valid <= 1'b1;
        i_in <= r;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    // Wait until the block is idle, then write one register.
    task automatic write_reg(logic [1:0] idx, logic [31:0] val);
        i_in_valid <= 1'b0;
        while (pending_predictions.size() != 0) @(posedge i_clk);
        repeat (30) @(posedge i_clk);
        @(negedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        if (idx == rbf_pkg::REG_POINT_COUNT) begin
            pc_reg = val[10:0];
        end else if (idx == rbf_pkg::REG_INV_SIGMA_SQ) begin
            inv_reg = val;
        end else if (idx == rbf_pkg::REG_BIAS) begin
            bias_reg = val;
        end
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    function automatic rbf_pkg::t_in mk_req(logic op, int idx, int x, int y, logic [31:0] w);
        rbf_pkg::t_in r;
        r.operation = op;
        r.point_index = idx[9:0];
        r.coord_x = x[23:0];
        r.coord_y = y[23:0];
        r.weight = w;
        return r;
    endfunction

    function automatic void add_req(rbf_pkg::t_in r, logic has_exp = 1'b0,
                                    logic signed [47:0] p = '0);
        t_row row;
        row = '{1'b0, rbf_pkg::REG_POINT_COUNT, 32'd0, r, has_exp, '{p, 1'b0}};
        directed.push_back(row);
    endfunction

    function automatic void add_cfg(logic [1:0] idx, logic [31:0] val);
        t_row row;
        row = '{1'b1, idx, val, '0, 1'b0, '0};
        directed.push_back(row);
    endfunction

    // Mostly clustered coordinates so kernels are nonzero, sometimes full range.
    function automatic int rnd_coord();
        if ($urandom_range(7) == 0) begin
            return int'($urandom);
        end
        return int'($urandom_range(2047)) - 1024;
    endfunction

    function automatic logic [31:0] rnd_inv();
        case ($urandom_range(5))
            0: return 32'd0;
            1: return 32'hFFFF_FFFF;
            2: return $urandom;
            default: return $urandom_range(32'h0100_0000);
        endcase
    endfunction

    // Stimulus.
    initial begin
        rbf_pkg::t_in r;
        int n_pts;
        build_exp_lut();
        failed = 1'b0;
        cycles = 0;
        idle_pct = 0;
        stall_pct = 0;
        pc_reg = rbf_pkg::POINT_COUNT_RESET;
        inv_reg = rbf_pkg::INV_SIGMA_SQ_RESET;
        bias_reg = rbf_pkg::BIAS_RESET;
        i_in_valid = 1'b0;
        i_in = '0;
        i_out_stall = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_index = rbf_pkg::REG_POINT_COUNT;
        i_cfg_data = '0;
        i_rst_n = 1'b0;
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed part: extremes of coordinates and weights, zero and full kernel width,
        // empty sum, unused register index.
        add_req(mk_req(rbf_pkg::OP_LOAD, 0, 8388607, -8388608, 32'h7FFF_FFFF));
        add_req(mk_req(rbf_pkg::OP_QUERY, 1023, 8388607, -8388608, 32'hFFFF_FFFF), 1'b1,
                48'sd2147483647);
        add_req(mk_req(rbf_pkg::OP_QUERY, 0, -8388608, 8388607, 32'h0), 1'b1, 48'sd0);
        add_cfg(rbf_pkg::REG_INV_SIGMA_SQ, 32'd0);
        add_req(mk_req(rbf_pkg::OP_QUERY, 0, -8388608, 8388607, 32'h0), 1'b1,
                48'sd2147483647);
        add_cfg(rbf_pkg::REG_BIAS, 32'h8000_0000);
        add_cfg(rbf_pkg::REG_POINT_COUNT, 32'd0);
        add_req(mk_req(rbf_pkg::OP_QUERY, 0, 5, 5, 32'h0), 1'b1, -48'sd2147483648);
        add_req(mk_req(rbf_pkg::OP_LOAD, 1, 0, 0, 32'h8000_0000));
        add_cfg(rbf_pkg::REG_POINT_COUNT, 32'd2);
        add_req(mk_req(rbf_pkg::OP_QUERY, 0, 0, 0, 32'h0), 1'b1, -48'sd2147483649);
        add_cfg(rbf_pkg::REG_INV_SIGMA_SQ, 32'hFFFF_FFFF);
        add_req(mk_req(rbf_pkg::OP_QUERY, 0, 0, 0, 32'h0), 1'b1, -48'sd4294967296);
        add_cfg(rbf_pkg::REG_INV_SIGMA_SQ, rbf_pkg::INV_SIGMA_SQ_RESET);
        add_cfg(rbf_pkg::REG_BIAS, 32'h7FFF_FFFF);
        add_req(mk_req(rbf_pkg::OP_LOAD, 1, 3, -4, 32'h0001_0000));
        add_req(mk_req(rbf_pkg::OP_QUERY, 0, 0, 0, 32'h0));
        add_cfg(REG_UNUSED, 32'h0000_0000);
        add_req(mk_req(rbf_pkg::OP_QUERY, 0, 1, 1, 32'h0));
        add_cfg(rbf_pkg::REG_POINT_COUNT, 32'd1);
        add_req(mk_req(rbf_pkg::OP_QUERY, 0, 8388607, -8388607, 32'h0));
        foreach (directed[k]) begin
            if (directed[k].is_cfg) begin
                write_reg(directed[k].cfg_idx, directed[k].cfg_val);
            end else begin
                send_request(directed[k].req, directed[k].has_exp, directed[k].exp);
            end
        end

        // Fill the first 64 slots with clustered random points.
        for (int i = 0; i < 64; i++) begin
            send_request(mk_req(rbf_pkg::OP_LOAD, i, rnd_coord(), rnd_coord(), $urandom));
        end

        // Random phases under changing configuration and handshake pressure.
        for (int ph = 0; ph < 8; ph++) begin
            case (ph % 4)
                0: begin idle_pct = 0; stall_pct = 0; end
                1: begin idle_pct = 49; stall_pct = 0; end
                2: begin idle_pct = 0; stall_pct = 49; end
                default: begin idle_pct = 10; stall_pct = 10; end
            endcase
            n_pts = (ph == 3) ? 64 : int'($urandom_range(20));
            write_reg(rbf_pkg::REG_POINT_COUNT, 32'(n_pts));
            write_reg(rbf_pkg::REG_INV_SIGMA_SQ, rnd_inv());
            write_reg(rbf_pkg::REG_BIAS, (ph == 5) ? 32'h8000_0000 : $urandom);
            for (int j = 0; j < 63; j++) begin
                if ($urandom_range(99) < 60) begin
                    r = mk_req(rbf_pkg::OP_QUERY, $urandom_range(1023), rnd_coord(),
                               rnd_coord(), $urandom);
                end else if ($urandom_range(4) == 0) begin
                    r = mk_req(rbf_pkg::OP_LOAD, $urandom_range(1023), rnd_coord(),
                               rnd_coord(), $urandom);
                end else begin
                    r = mk_req(rbf_pkg::OP_LOAD, $urandom_range(63), rnd_coord(),
                               rnd_coord(), $urandom);
                end
                send_request(r);
            end
        end
        i_in_valid <= 1'b0;

        // Drain.
        while (pending_predictions.size() != 0) @(posedge i_clk);
        repeat (50) @(posedge i_clk);
        if (!failed) begin
            $display("tb_rbf_kernel_regression_eval_top passed");
        end else begin
            $display("tb_rbf_kernel_regression_eval_top failed");
        end
        $finish;
    end

endmodule

### sim.f
design/rbf_pkg.sv
design/rbf_kernel_regression_eval_top.sv
tb/tb_rbf_kernel_regression_eval_top.sv
